/* rtl/ppsc_pkg.sv */
// ----------------------------------------------------------------------------
// ppsc_pkg: shared types and codes of the ping-pong sample capture
// Request and result payloads, command, kind and error codes, control states.
// ----------------------------------------------------------------------------
package ppsc_pkg;

	localparam int BANK_COUNT = 2;
	localparam int IN_SLOTS    = 5;
	localparam int STAMP_W     = 16;
	localparam int CHAN_W      = 12;
	localparam int COUNT_W     = 5;
	localparam int CCOUNT_W    = 3;

	localparam logic CMD_CAPTURE = 1'b0;
	localparam logic CMD_DRAIN   = 1'b1;

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DRAINED  = 2'd1;
	localparam logic [1:0] KIND_EMPTY    = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_FAULT    = 2'd2;

	typedef struct packed {
		logic              command;
		logic [STAMP_W-1:0] timestamp;
		logic              conversion_fault;
		logic [CHAN_W-1:0]  chan0_value;
		logic [CHAN_W-1:0]  chan1_value;
		logic [CHAN_W-1:0]  chan2_value;
		logic [CHAN_W-1:0]  chan3_value;
		logic [CHAN_W-1:0]  chan4_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         error_code;
		logic               buffer_swapped;
		logic [COUNT_W-1:0] sample_count;
		logic [STAMP_W-1:0] out_timestamp;
		logic [CHAN_W-1:0]  out_chan0;
		logic [CHAN_W-1:0]  out_chan1;
		logic [CHAN_W-1:0]  out_chan2;
		logic [CHAN_W-1:0]  out_chan3;
		logic [CHAN_W-1:0]  out_chan4;
		logic               last;
	} result_t;

	// status from the controller to the output stage
	typedef struct packed {
		logic res_valid;
		logic drain_valid;
		logic drain_last;
	} ctrl_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

/* rtl/ppsc_store.sv */
// ----------------------------------------------------------------------------
// ppsc_store: sample memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ppsc_store #(
	parameter int AW = 5,
	parameter int DW = 76
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/ppsc_ctrl.sv */
// ----------------------------------------------------------------------------
// ppsc_ctrl: capture and drain sequencer
// Keeps fill counts and the active buffer, writes captured samples, walks the
// ready buffer on a drain and forms capture and empty-drain results.
// ----------------------------------------------------------------------------
module ppsc_ctrl import ppsc_pkg::*; #(
	parameter int SAMPLES_PER_BUFFER = 16,
	parameter int MAX_CHANNELS       = 5,
	parameter int AW                 = 5,
	parameter int DW                 = 76
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  item_t               item,
	input  logic                cfg_valid,
	input  logic [CCOUNT_W-1:0] cfg_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [DW-1:0]       wr_data,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	output result_t             res,
	output ctrl_stat_t          stat
);

	localparam int IW    = AW - 1;
	localparam int CW    = $clog2(SAMPLES_PER_BUFFER + 1);
	localparam int SLOTS = (MAX_CHANNELS > IN_SLOTS) ? MAX_CHANNELS : IN_SLOTS;
	localparam int WW    = STAMP_W + CHAN_W * SLOTS;

	state_t              state_q, state_d;
	logic [CW-1:0]       fill_q [BANK_COUNT];
	logic                active_q;
	logic [CCOUNT_W-1:0] chan_cnt_q;
	logic [IW-1:0]       rd_idx_q, rd_last_q;
	logic                drain_buf_q;
	logic                res_valid_q, drain_s1, last_s1;
	result_t             res_q, res_d;

	logic                accept, is_cap, full, cap_ok, swap, drain_go, drain_end;
	logic [CW-1:0]       cur_cnt, rdy_cnt, cnt_inc;
	logic [CHAN_W-1:0]   in_chan [IN_SLOTS];
	logic [WW-1:0]       word;

	assign accept    = start && !busy;
	assign is_cap    = (item.command == CMD_CAPTURE);
	assign cur_cnt   = fill_q[active_q];
	assign rdy_cnt   = fill_q[~active_q];
	assign cnt_inc   = cur_cnt + 1'b1;
	assign full      = (cur_cnt == CW'(SAMPLES_PER_BUFFER));
	assign cap_ok    = accept && is_cap && !full && !item.conversion_fault;
	assign swap      = cap_ok && (cnt_inc == CW'(SAMPLES_PER_BUFFER));
	assign drain_go  = accept && !is_cap && (rdy_cnt != '0);
	assign drain_end = (state_q == ST_DRAIN) && (rd_idx_q == rd_last_q);

	assign in_chan[0] = item.chan0_value;
	assign in_chan[1] = item.chan1_value;
	assign in_chan[2] = item.chan2_value;
	assign in_chan[3] = item.chan3_value;
	assign in_chan[4] = item.chan4_value;

	// sample row: timestamp, then used slots (slot 0 always); slots past the channel count stay zero
	always_comb begin
		word = '0;
		word[STAMP_W-1:0] = item.timestamp;
		for (int j = 0; j < IN_SLOTS; j++) begin
			if (j < MAX_CHANNELS && (j == 0 || CCOUNT_W'(j) < chan_cnt_q)) begin
				word[STAMP_W + CHAN_W*j +: CHAN_W] = in_chan[j];
			end
		end
	end

	assign wr_en   = cap_ok;
	assign wr_addr = {active_q, cur_cnt[IW-1:0]};
	assign wr_data = word[DW-1:0];
	assign rd_addr = {drain_buf_q, rd_idx_q};

	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		if (is_cap) begin
			if (full) begin
				res_d.kind         = KIND_ERROR;
				res_d.error_code   = ERR_OVERFLOW;
				res_d.sample_count = COUNT_W'(cur_cnt);
			end else if (item.conversion_fault) begin
				res_d.kind         = KIND_ERROR;
				res_d.error_code   = ERR_FAULT;
				res_d.sample_count = COUNT_W'(cur_cnt);
			end else begin
				res_d.kind           = KIND_ACCEPTED;
				res_d.buffer_swapped = swap;
				res_d.sample_count   = COUNT_W'(cnt_inc);
			end
		end else begin
			res_d.kind = KIND_EMPTY;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (drain_go) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_DRAIN: rd_en = 1'b1;
			default: begin
				busy  = 1'b1;
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			active_q    <= 1'b0;
			chan_cnt_q  <= CCOUNT_W'(1);
			res_valid_q <= 1'b0;
			drain_s1    <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= accept && !drain_go;
			drain_s1    <= rd_en;
			last_s1     <= drain_end;
			if (cfg_valid) begin
				chan_cnt_q <= cfg_data;
			end
			if (cap_ok) begin
				fill_q[active_q] <= cnt_inc;
			end
			if (swap) begin
				active_q <= ~active_q;
			end
			// free the drained buffer once its last row is read
			if (drain_end) begin
				fill_q[drain_buf_q] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q       <= res_d;
			drain_buf_q <= ~active_q;
			rd_idx_q    <= '0;
			rd_last_q   <= IW'(rdy_cnt - 1'b1);
		end else if (rd_en) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	assign res              = res_q;
	assign stat.res_valid   = res_valid_q;
	assign stat.drain_valid = drain_s1;
	assign stat.drain_last  = last_s1;

endmodule

/* rtl/ping_pong_sample_capture.sv */
// ----------------------------------------------------------------------------
// ping_pong_sample_capture: double-buffered capture of converter sequences
// Two sample buffers in one memory; captures fill one, drains empty the other.
// ----------------------------------------------------------------------------
// Usage:
//   A request (item) is taken at a clock edge with start high and busy low.
//   A capture stores timestamp and channel values in the active buffer and
//   gives one result in the next cycle; busy stays low, so captures can come
//   every cycle. A full buffer swaps the active buffer.
//   A drain of n stored samples raises busy while the sequencer walks the
//   memory one row a cycle; results follow the registered reads, one per
//   cycle, the last one marked. An empty drain gives one result in the
//   next cycle.
//   Each result is on result for one cycle with result_valid high; the
//   receiver cannot stall, so none is held back.
//   channel_count is to be written through cfg_valid/cfg_data only while idle;
//   the block does not enforce this, and cfg_ready is always high.
//   Reset clears both fill counts, selects buffer zero as active and sets the
//   channel count to one. The memory needs no clearing: only written rows
//   are ever read.
// ----------------------------------------------------------------------------
module ping_pong_sample_capture import ppsc_pkg::*; #(
	parameter int SAMPLES_PER_BUFFER = 16,
	parameter int MAX_CHANNELS       = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  item_t               item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CCOUNT_W-1:0] cfg_data,
	output logic                result_valid,
	output result_t             result
);

	localparam int AW    = $clog2(SAMPLES_PER_BUFFER) + 1;
	localparam int DW    = STAMP_W + CHAN_W * MAX_CHANNELS;
	localparam int SLOTS = (MAX_CHANNELS > IN_SLOTS) ? MAX_CHANNELS : IN_SLOTS;
	localparam int WW    = STAMP_W + CHAN_W * SLOTS;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data, rd_data;
	logic [WW-1:0] rd_wide;
	result_t       res, drained;
	ctrl_stat_t    stat;

	ppsc_ctrl #(
		.SAMPLES_PER_BUFFER(SAMPLES_PER_BUFFER),
		.MAX_CHANNELS      (MAX_CHANNELS),
		.AW                (AW),
		.DW                (DW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.res      (res),
		.stat     (stat)
	);

	ppsc_store #(
		.AW(AW),
		.DW(DW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// slots beyond the stored channels read as zero
	assign rd_wide = WW'(rd_data);

	always_comb begin
		drained               = '0;
		drained.kind          = KIND_DRAINED;
		drained.out_timestamp = rd_wide[STAMP_W-1:0];
		drained.out_chan0     = rd_wide[STAMP_W + CHAN_W*0 +: CHAN_W];
		drained.out_chan1     = rd_wide[STAMP_W + CHAN_W*1 +: CHAN_W];
		drained.out_chan2     = rd_wide[STAMP_W + CHAN_W*2 +: CHAN_W];
		drained.out_chan3     = rd_wide[STAMP_W + CHAN_W*3 +: CHAN_W];
		drained.out_chan4     = rd_wide[STAMP_W + CHAN_W*4 +: CHAN_W];
		drained.last          = stat.drain_last;
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = stat.res_valid || stat.drain_valid;
	assign result       = stat.drain_valid ? drained : res;

endmodule

/* rtl/ppsc_checker.sv */
// ----------------------------------------------------------------------------
// ppsc_checker: port-level checks of the ping-pong sample capture
// Watches request and result ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module ppsc_checker import ppsc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    result_valid,
	input result_t result
);

	// only drained samples may be followed by more results of the same request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_DRAINED |-> result.last)
		else $error("non-drain result without last");

	a_drain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DRAINED |->
		result.sample_count == '0 && result.error_code == ERR_NONE &&
		!result.buffer_swapped)
		else $error("drained sample carries capture status");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_DRAINED |->
		result.out_timestamp == '0 && result.out_chan0 == '0 &&
		result.out_chan1 == '0 && result.out_chan2 == '0 &&
		result.out_chan3 == '0 && result.out_chan4 == '0)
		else $error("sample payload on a non-drain result");

	a_capture_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == CMD_CAPTURE |=>
		result_valid && result.last)
		else $error("capture request without result in next cycle");

	a_drain_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last && result.kind == KIND_DRAINED |=>
		result_valid && result.kind == KIND_DRAINED)
		else $error("drain burst broken before its last sample");

endmodule

bind ping_pong_sample_capture ppsc_checker u_ppsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);

/* dv/ping_pong_sample_capture_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ping_pong_sample_capture_tb: self-checking bench for the sample capture
// Drives capture and drain requests with random gaps under several channel
// counts, predicts every result from its own copy of the buffers and checks
// each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ping_pong_sample_capture_tb;
	import ppsc_pkg::*;

	localparam int SPB        = 16;
	localparam int SLOTS      = 5;
	localparam int LIMIT      = 200000;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_REQS = 15;

	class capture_scoreboard;
		logic [STAMP_W-1:0] stamps [BANK_COUNT*SPB];
		logic [CHAN_W-1:0]  values [BANK_COUNT*SPB][SLOTS];
		int unsigned        fill [BANK_COUNT];
		bit                 active;
		logic [CCOUNT_W-1:0] chan_setting;
		result_t            pending [$];
		int unsigned errors, results, captures, drains, swaps, overflows, faults;

		function new();
			fill[0] = 0;
			fill[1] = 0;
			active = 1'b0;
			chan_setting = 3'd1;
			errors = 0;
			results = 0;
			captures = 0;
			drains = 0;
			swaps = 0;
			overflows = 0;
			faults = 0;
		endfunction

		function void set_channels(logic [CCOUNT_W-1:0] v);
			chan_setting = v;
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction

		// work out the results of one accepted request
		function void note_request(item_t it);
			result_t r;
			logic [CHAN_W-1:0] vals [SLOTS];
			int unsigned cnt, nch, row, ready, n;
			bit buf_sel;
			vals[0] = it.chan0_value;
			vals[1] = it.chan1_value;
			vals[2] = it.chan2_value;
			vals[3] = it.chan3_value;
			vals[4] = it.chan4_value;
			r = '0;
			r.last = 1'b1;
			if (it.command == CMD_CAPTURE) begin
				captures++;
				buf_sel = active;
				cnt = fill[buf_sel];
				r.sample_count = COUNT_W'(cnt);
				if (cnt >= SPB) begin
					overflows++;
					r.kind = KIND_ERROR;
					r.error_code = ERR_OVERFLOW;
				end else if (it.conversion_fault) begin
					faults++;
					r.kind = KIND_ERROR;
					r.error_code = ERR_FAULT;
				end else begin
					nch = chan_setting;
					if (nch < 1) nch = 1;
					if (nch > SLOTS) nch = SLOTS;
					row = buf_sel * SPB + cnt;
					stamps[row] = it.timestamp;
					for (int j = 0; j < SLOTS; j++)
						values[row][j] = (j < nch) ? vals[j] : '0;
					cnt++;
					fill[buf_sel] = cnt;
					if (cnt == SPB) begin
						active = ~buf_sel;
						r.buffer_swapped = 1'b1;
						swaps++;
					end
					r.kind = KIND_ACCEPTED;
					r.sample_count = COUNT_W'(cnt);
				end
				pending.push_back(r);
			end else begin
				drains++;
				ready = active ? 0 : 1;
				n = fill[ready];
				if (n == 0) begin
					r.kind = KIND_EMPTY;
					pending.push_back(r);
				end else begin
					for (int i = 0; i < n; i++) begin
						row = ready * SPB + i;
						r = '0;
						r.kind = KIND_DRAINED;
						r.out_timestamp = stamps[row];
						r.out_chan0 = values[row][0];
						r.out_chan1 = values[row][1];
						r.out_chan2 = values[row][2];
						r.out_chan3 = values[row][3];
						r.out_chan4 = values[row][4];
						r.last = (i == n - 1);
						pending.push_back(r);
					end
					fill[ready] = 0;
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (a !== e) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, a);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			results++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, got 0x%0h", $time, got);
				return;
			end
			e = pending.pop_front();
			compare_field("kind", e.kind, got.kind);
			compare_field("error_code", e.error_code, got.error_code);
			compare_field("buffer_swapped", e.buffer_swapped, got.buffer_swapped);
			compare_field("sample_count", e.sample_count, got.sample_count);
			compare_field("out_timestamp", e.out_timestamp, got.out_timestamp);
			compare_field("out_chan0", e.out_chan0, got.out_chan0);
			compare_field("out_chan1", e.out_chan1, got.out_chan1);
			compare_field("out_chan2", e.out_chan2, got.out_chan2);
			compare_field("out_chan3", e.out_chan3, got.out_chan3);
			compare_field("out_chan4", e.out_chan4, got.out_chan4);
			compare_field("last", e.last, got.last);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	item_t               item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CCOUNT_W-1:0] cfg_data;
	logic                result_valid;
	result_t             result;

	capture_scoreboard sb = new();
	int unsigned cycles = 0;

	ping_pong_sample_capture dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles, sb.outstanding());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic item_t random_capture(int fault_pct);
		item_t it;
		it.command          = CMD_CAPTURE;
		it.timestamp        = STAMP_W'($urandom);
		it.conversion_fault = ($urandom_range(99) < fault_pct);
		it.chan0_value      = CHAN_W'($urandom);
		it.chan1_value      = CHAN_W'($urandom);
		it.chan2_value      = CHAN_W'($urandom);
		it.chan3_value      = CHAN_W'($urandom);
		it.chan4_value      = CHAN_W'($urandom);
		return it;
	endfunction

	function automatic item_t random_drain();
		item_t it;
		it = random_capture(50);
		it.command = CMD_DRAIN;
		return it;
	endfunction

	// hold start low for a random number of cycles, then present one request
	task automatic send_request(item_t it, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		sb.note_request(it);
	endtask

	task automatic drop_start();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_channels(logic [CCOUNT_W-1:0] v);
		drop_start();
		wait_drained();
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_channels(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		item_t it;
		logic [CCOUNT_W-1:0] phase_cfg [NUM_PHASES];
		int phase_idle [NUM_PHASES];
		int until_drain;

		phase_cfg  = '{3'd5, 3'd0, 3'd7, 3'd2, 3'd6, 3'd3};
		phase_idle = '{0, 52, 22, 52, 0, 22};

		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty drain, extreme values, fault, fill to swap, full drain
		send_request(random_drain(), 0);
		it = random_capture(0);
		it.timestamp = '0;
		it.chan0_value = '0;
		it.chan1_value = '0;
		it.chan2_value = '0;
		it.chan3_value = '0;
		it.chan4_value = '0;
		send_request(it, 0);
		it.timestamp = '1;
		it.chan0_value = '1;
		it.chan1_value = '1;
		it.chan2_value = '1;
		it.chan3_value = '1;
		it.chan4_value = '1;
		send_request(it, 0);
		it.conversion_fault = 1'b1;
		send_request(it, 0);
		for (int i = 0; i < SPB - 2; i++)
			send_request(random_capture(0), 0);
		drop_start();
		wait_drained();
		send_request(random_drain(), 0);
		send_request(random_drain(), 0);

		// random: runs of captures closed by a drain, long runs overflow both buffers
		until_drain = $urandom_range(0, 40);
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_channels(phase_cfg[p]);
			for (int n = 0; n < PHASE_REQS; n++) begin
				if ($urandom_range(9) == 0) begin
					drop_start();
					wait_drained();
				end
				if (until_drain == 0 || $urandom_range(19) == 0) begin
					send_request(random_drain(), phase_idle[p]);
					until_drain = $urandom_range(0, 40);
				end else begin
					send_request(random_capture(10), phase_idle[p]);
					until_drain--;
				end
			end
		end

		drop_start();
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected results never arrived", $time, sb.outstanding());
		end
		$display("Covered %0d captures and %0d drains over %0d channel settings: %0d results",
			sb.captures, sb.drains, NUM_PHASES + 1, sb.results);
		$display("Seen %0d buffer swaps, %0d overflow drops, %0d fault drops",
			sb.swaps, sb.overflows, sb.faults);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/ppsc_pkg.sv
rtl/ppsc_store.sv
rtl/ppsc_ctrl.sv
rtl/ping_pong_sample_capture.sv
rtl/ppsc_checker.sv
dv/ping_pong_sample_capture_tb.sv
